/* rtl/core/acs_pkg.sv */
package acs_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned RegCount = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  localparam logic [3:0] OP_LDR = 4'h0;
  localparam logic [3:0] OP_LDI = 4'h1;
  localparam logic [3:0] OP_STR = 4'h2;
  localparam logic [3:0] OP_ADD = 4'h3;
  localparam logic [3:0] OP_SUB = 4'h4;
  localparam logic [3:0] OP_MUL = 4'h5;
  localparam logic [3:0] OP_DIV = 4'h6;
  localparam logic [3:0] OP_JMP = 4'h7;
  localparam logic [3:0] OP_JGE = 4'h8;
  localparam logic [3:0] OP_JGT = 4'h9;
  localparam logic [3:0] OP_JLE = 4'hA;
  localparam logic [3:0] OP_JLT = 4'hB;
  localparam logic [3:0] OP_JEQ = 4'hC;
  localparam logic [3:0] OP_JNE = 4'hD;
  localparam logic [3:0] OP_HLT = 4'hE;
  localparam logic [3:0] OP_OUT = 4'hF;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

/* rtl/core/acs_alu.sv */
module acs_alu
  import acs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [DataW-1:0]    rem_q;
  logic [DataW-1:0]    quo_q;
  logic [DataW-1:0]    mb_q;
  logic                neg_q;
  logic [DataW-1:0]    res_q;

  logic [DataW-1:0]    abs_a;
  logic [DataW-1:0]    abs_b;
  logic [2*DataW-1:0]  prod;
  logic [DataW-1:0]    quick_res;
  logic [DataW-1:0]    rem_sh;
  logic                ge;
  logic [DataW-1:0]    rem_nx;
  logic [DataW-1:0]    quo_nx;

  assign abs_a = req_i.a[DataW-1] ? DataW'(-req_i.a) : req_i.a;
  assign abs_b = req_i.b[DataW-1] ? DataW'(-req_i.b) : req_i.b;
  assign prod  = {{DataW{1'b0}}, req_i.a} * {{DataW{1'b0}}, req_i.b};

  always_comb begin
    case (req_i.op)
      ALU_ADD: quick_res = DataW'(req_i.a + req_i.b);
      ALU_SUB: quick_res = DataW'(req_i.a - req_i.b);
      ALU_MUL: quick_res = prod[DataW-1:0];
      default: quick_res = '0;
    endcase
  end

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q[DataW-2:0], quo_q[DataW-1]};
  assign ge     = (rem_sh >= mb_q);
  assign rem_nx = ge ? DataW'(rem_sh - mb_q) : rem_sh;
  assign quo_nx = {quo_q[DataW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= (req_i.op == ALU_DIV);
      done_q <= (req_i.op != ALU_DIV);
      cnt_q  <= StepCntW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepCntW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= abs_a;
      mb_q  <= abs_b;
      neg_q <= req_i.a[DataW-1] ^ req_i.b[DataW-1];
      res_q <= quick_res;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
      if (cnt_q == '0) begin
        res_q <= neg_q ? DataW'(-quo_nx) : quo_nx;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

/* rtl/core/accumulator_cpu_step.sv */
// Accumulator processor, one item at a time. A load item (cmd 0) writes one
// byte of program memory and passes through S_FIN to the output register.
// A step item (cmd 1) executes the instruction at the program counter in
// S_EXEC: moves, stores, jumps, halt, output and a divide by zero then go to
// S_FIN; add, subtract, multiply and divide wait in S_WAIT for the shared
// ALU, whose restoring divider produces one quotient bit per cycle. A step while
// halted goes straight to S_FIN. in_stall_o stays high until the result has been
// placed in the output register; a result waiting there does not block the
// next item until that item's own result is ready. Program memory and
// registers read as zero after reset.
module accumulator_cpu_step
  import acs_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MemDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [7:0]        load_addr_i,
  input  logic [7:0]        load_byte_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output logic [7:0]        prog_counter_o,
  output logic signed [7:0] accumulator_o,
  output logic              out_valid_o,
  output logic [7:0]        out_value_o,
  output logic              halted_o,
  output logic              div_zero_o
);

  localparam int unsigned AddrW = $clog2(MEM_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state_q;
  logic [7:0]           pc_q;
  logic [DataW-1:0]     acc_q;
  logic                 halt_q;
  logic                 outv_q;
  logic                 dz_q;
  logic [DataW-1:0]     rf_q [RegCount];

  logic [7:0]           mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [7:0]           rd_q;
  logic                 vld_rd_q;

  logic                 res_valid_q;
  logic [7:0]           res_pc_q;
  logic [DataW-1:0]     res_acc_q;
  logic                 res_outv_q;
  logic [7:0]           res_outval_q;
  logic                 res_halt_q;
  logic                 res_dz_q;

  logic                 in_acc;
  logic                 ld_in_rng;
  logic                 pc_in_rng;
  logic                 ld_we;
  logic [AddrW-1:0]     ld_idx;
  logic [AddrW-1:0]     pc_idx;
  logic [7:0]           instr;
  logic [3:0]           opc;
  logic [3:0]           nib;
  logic [DataW-1:0]     r_val;
  logic                 a_neg;
  logic                 a_zero;
  logic                 take;
  logic [7:0]           pc_nx;
  logic                 fin_load;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_in_rng  = ({1'b0, load_addr_i} < 9'(MEM_DEPTH));
  assign pc_in_rng  = ({1'b0, pc_q} < 9'(MEM_DEPTH));
  assign ld_idx     = load_addr_i[AddrW-1:0];
  assign pc_idx     = pc_q[AddrW-1:0];
  assign ld_we      = in_acc && !cmd_i && ld_in_rng;

  assign instr  = vld_rd_q ? rd_q : 8'h00;
  assign opc    = instr[7:4];
  assign nib    = instr[3:0];
  assign r_val  = rf_q[nib];
  assign a_neg  = acc_q[DataW-1];
  assign a_zero = (acc_q == '0);

  always_comb begin
    case (opc)
      OP_JMP:  take = 1'b1;
      OP_JGE:  take = !a_neg;
      OP_JGT:  take = !a_neg && !a_zero;
      OP_JLE:  take = a_neg || a_zero;
      OP_JLT:  take = a_neg;
      OP_JEQ:  take = a_zero;
      OP_JNE:  take = !a_zero;
      default: take = 1'b0;
    endcase
  end

  assign pc_nx = (opc == OP_HLT) ? pc_q : (take ? 8'(nib) : pc_q + 8'd1);

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.a     = acc_q;
    alu_req.b     = r_val;
    case (opc)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase
    if (state_q == S_EXEC) begin
      alu_req.start = (opc == OP_ADD) || (opc == OP_SUB) || (opc == OP_MUL) ||
                      ((opc == OP_DIV) && (r_val != '0));
    end
  end

  acs_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem_q[ld_idx] <= load_byte_i;
    end
    if (pc_in_rng) begin
      rd_q <= mem_q[pc_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= pc_in_rng && vld_q[pc_idx];
      if (ld_we) begin
        vld_q[ld_idx] <= 1'b1;
      end
    end
  end

  assign fin_load = (state_q == S_FIN) && (!res_valid_q || !res_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      acc_q   <= '0;
      halt_q  <= 1'b0;
      outv_q  <= 1'b0;
      dz_q    <= 1'b0;
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            outv_q  <= 1'b0;
            dz_q    <= 1'b0;
            state_q <= (cmd_i && !halt_q) ? S_EXEC : S_FIN;
          end
        end
        S_EXEC: begin
          state_q <= alu_req.start ? S_WAIT : S_FIN;
          pc_q    <= pc_nx;
          unique case (opc) inside
            OP_LDR: acc_q <= r_val;
            OP_LDI: acc_q <= DataW'(nib);
            OP_STR: rf_q[nib] <= acc_q;
            OP_ADD, OP_SUB, OP_MUL,
            OP_JMP, OP_JGE, OP_JGT, OP_JLE, OP_JLT, OP_JEQ, OP_JNE: begin
            end
            OP_DIV: begin
              if (r_val == '0) begin
                dz_q <= 1'b1;
              end
            end
            OP_HLT: halt_q <= 1'b1;
            default: outv_q <= 1'b1;
          endcase
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            acc_q   <= alu_rsp.result;
            state_q <= S_FIN;
          end
        end
        default: begin
          if (fin_load) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fin_load) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      res_pc_q     <= pc_q;
      res_acc_q    <= acc_q;
      res_outv_q   <= outv_q;
      res_outval_q <= outv_q ? acc_q : 8'h00;
      res_halt_q   <= halt_q;
      res_dz_q     <= dz_q;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign prog_counter_o = res_pc_q;
  assign accumulator_o  = res_acc_q;
  assign out_valid_o    = res_outv_q;
  assign out_value_o    = res_outval_q;
  assign halted_o       = res_halt_q;
  assign div_zero_o     = res_dz_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_alu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_WAIT))
    else $error("ALU finished outside of wait state");

  a_res_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result appeared without finishing an item");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_outv_q && res_dz_q))
    else $error("output and divide-by-zero flagged together");

endmodule

/* dv/accumulator_cpu_step_tb.sv */
`timescale 1ns / 1ps

module accumulator_cpu_step_tb;
  import acs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumItems   = 1450;

  typedef struct {
    logic [7:0]        pc;
    logic signed [7:0] acc;
    logic              outv;
    logic [7:0]        outval;
    logic              halted;
    logic              dz;
  } cpu_result_t;

  class cpu_scoreboard;
    logic [7:0]  prog_mem [MemDepth];
    logic [7:0]  regs [RegCount];
    logic [7:0]  acc;
    logic [7:0]  pc;
    logic        halted;
    cpu_result_t pending [$];
    int          errors;

    function new();
      foreach (prog_mem[i]) prog_mem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      acc    = '0;
      pc     = '0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function void note_item(logic cmd, logic [7:0] addr, logic [7:0] data);
      cpu_result_t       res;
      logic [7:0]        instr;
      logic [7:0]        r;
      logic [7:0]        nxt;
      logic signed [7:0] a;
      logic              take;
      int                q;
      res.outv   = 1'b0;
      res.outval = '0;
      res.dz     = 1'b0;
      if (!cmd) begin
        prog_mem[addr] = data;
      end else if (!halted) begin
        instr = prog_mem[pc];
        r     = regs[instr[3:0]];
        a     = acc;
        nxt   = pc + 8'd1;
        take  = 1'b0;
        case (instr[7:4])
          OP_LDR: acc = r;
          OP_LDI: acc = {4'h0, instr[3:0]};
          OP_STR: regs[instr[3:0]] = acc;
          OP_ADD: acc = acc + r;
          OP_SUB: acc = acc - r;
          OP_MUL: acc = acc * r;
          OP_DIV: begin
            if (r == 8'd0) begin
              res.dz = 1'b1;
            end else begin
              q   = int'(a) / int'($signed(r));
              acc = q[7:0];
            end
          end
          OP_JMP: take = 1'b1;
          OP_JGE: take = (a >= 0);
          OP_JGT: take = (a > 0);
          OP_JLE: take = (a <= 0);
          OP_JLT: take = (a < 0);
          OP_JEQ: take = (a == 0);
          OP_JNE: take = (a != 0);
          OP_HLT: begin
            halted = 1'b1;
            nxt    = pc;
          end
          OP_OUT: begin
            res.outv   = 1'b1;
            res.outval = acc;
          end
        endcase
        if (take) nxt = {4'h0, instr[3:0]};
        pc = nxt;
      end
      res.pc     = pc;
      res.acc    = acc;
      res.halted = halted;
      pending.push_back(res);
    endfunction

    function void check_result(logic [7:0] pc_o, logic signed [7:0] acc_o, logic outv_o,
                               logic [7:0] outval_o, logic halted_o, logic dz_o);
      cpu_result_t want;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (pc_o !== want.pc) begin
        $error("prog_counter: expected %0d, got %0d", want.pc, pc_o);
        errors++;
      end
      if (acc_o !== want.acc) begin
        $error("accumulator: expected %0d, got %0d", want.acc, acc_o);
        errors++;
      end
      if (outv_o !== want.outv) begin
        $error("out_valid: expected %0d, got %0d", want.outv, outv_o);
        errors++;
      end
      if (outval_o !== want.outval) begin
        $error("out_value: expected %0d, got %0d", want.outval, outval_o);
        errors++;
      end
      if (halted_o !== want.halted) begin
        $error("halted: expected %0d, got %0d", want.halted, halted_o);
        errors++;
      end
      if (dz_o !== want.dz) begin
        $error("div_zero: expected %0d, got %0d", want.dz, dz_o);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              cmd_i       = 1'b0;
  logic [7:0]        load_addr_i = '0;
  logic [7:0]        load_byte_i = '0;
  logic              res_stall_i = 1'b0;
  logic              in_stall_o;
  logic              res_valid_o;
  logic [7:0]        prog_counter_o;
  logic signed [7:0] accumulator_o;
  logic              out_valid_o;
  logic [7:0]        out_value_o;
  logic              halted_o;
  logic              div_zero_o;

  cpu_scoreboard sb = new();
  int            items_sent = 0;
  int            idle_pct   = 0;
  int            stall_pct  = 0;
  int unsigned   cycle_cnt  = 0;

  accumulator_cpu_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .load_addr_i   (load_addr_i),
    .load_byte_i   (load_byte_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .prog_counter_o(prog_counter_o),
    .accumulator_o (accumulator_o),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value_o),
    .halted_o      (halted_o),
    .div_zero_o    (div_zero_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      sb.check_result(prog_counter_o, accumulator_o, out_valid_o, out_value_o,
                      halted_o, div_zero_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    load_addr_i <= addr;
    load_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(cmd, addr, data);
    items_sent++;
  endtask

  task automatic step_cpu();
    send_item(1'b1, 8'($urandom), 8'($urandom));
  endtask

  // random instruction, never a halt
  function automatic logic [7:0] rand_instr(bit allow_jump);
    logic [3:0] op;
    if (allow_jump) begin
      op = 4'($urandom_range(0, 14));
      if (op == OP_HLT) op = OP_OUT;
    end else begin
      op = 4'($urandom_range(0, 7));
      if (op == OP_JMP) op = OP_OUT;
    end
    return {op, 4'($urandom_range(0, 15))};
  endfunction

  initial begin
    logic [7:0] boot_prog [$];
    logic [7:0] base;
    boot_prog = '{{OP_LDI, 4'd1}, {OP_STR, 4'd1}, {OP_LDI, 4'd0}, {OP_SUB, 4'd1},
                  {OP_STR, 4'd2}, {OP_LDI, 4'd8}, {OP_STR, 4'd3}, {OP_MUL, 4'd3},
                  {OP_STR, 4'd4}, {OP_ADD, 4'd4}, {OP_DIV, 4'd2}, {OP_DIV, 4'd5},
                  {OP_OUT, 4'd0}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // -1 and -8 in registers, -16 / -1, divide by zero, output
    foreach (boot_prog[i]) send_item(1'b0, 8'(i), boot_prog[i]);
    send_item(1'b0, 8'hFF, 8'hFF);
    repeat (boot_prog.size()) step_cpu();

    // straight-line run long enough to wrap the program counter
    base = sb.pc;
    for (int i = 1; i <= 32; i++) send_item(1'b0, base + 8'(i), rand_instr(1'b0));
    repeat (250) step_cpu();

    while (items_sent < NumItems) begin
      case ((items_sent / 180) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(9) == 0) send_item(1'b0, 8'($urandom), rand_instr(1'b1));
        else send_item(1'b0, 8'($urandom_range(0, 31)), rand_instr(1'b1));
      end
      repeat ($urandom_range(1, 24)) step_cpu();
    end

    // halt, step while halted, load while halted
    send_item(1'b0, sb.pc, {OP_HLT, 4'($urandom_range(0, 15))});
    step_cpu();
    step_cpu();
    send_item(1'b0, 8'($urandom), 8'($urandom));
    step_cpu();
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/acs_pkg.sv
rtl/core/acs_alu.sv
rtl/core/accumulator_cpu_step.sv
dv/accumulator_cpu_step_tb.sv
